// File: rtl/core/fpd_pkg.sv
// Shared types and constants of the form parameter decoder.
`default_nettype none

package fpd_pkg;

   // Most events that one input transaction can cause.
   localparam int unsigned MaxEvents = 4;
   localparam int unsigned CountW    = 3;

   localparam logic [1:0] KIND_OPEN  = 2'd0;
   localparam logic [1:0] KIND_NAME  = 2'd1;
   localparam logic [1:0] KIND_VALUE = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } evt_type;

   // All events of one input transaction, in order, slot 0 first.
   typedef struct packed {
      evt_type [MaxEvents-1:0] evts;
      logic [CountW-1:0]       count;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

// File: rtl/core/fpd_stream_if.sv
// Valid/ready channel interfaces for the request bytes and the result events.
`default_nettype none

interface fpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink (input valid, input ch, input last, output ready);
endinterface

interface fpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data;
   logic       run_end;

   modport source (output valid, output kind, output data, output run_end, input ready);
   modport sink (input valid, input kind, input data, input run_end, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fpd_front.sv
// Front end: accepts bytes, runs the escape and separator logic, builds event bundles.
`default_nettype none

module fpd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   fpd_req_if.sink                  req,
   input  wire fpd_pkg::qstat_type  q_stat,
   output logic                     push,
   output fpd_pkg::bundle_type      bundle
);

   localparam logic [1:0] ESC_IDLE = 2'd0;
   localparam logic [1:0] ESC_PCT  = 2'd1;
   localparam logic [1:0] ESC_DIG  = 2'd2;

   localparam logic [7:0] CharPct = 8'h25;
   localparam logic [7:0] CharAmp = 8'h26;
   localparam logic [7:0] CharEq  = 8'h3D;
   localparam logic [4:0] NotHex  = 5'd16;

   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] v;
      v = NotHex;
      if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
      else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h61 + 8'd10);
      else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h41 + 8'd10);
      return v;
   endfunction

   function automatic fpd_pkg::evt_type mk_evt(input logic [1:0] k, input logic [7:0] d);
      fpd_pkg::evt_type e;
      e.kind = k;
      e.data = d;
      return e;
   endfunction

   logic [1:0] esc_ff, esc_in;
   logic [3:0] nib_ff, nib_in;
   logic [7:0] dig_ff, dig_in;
   logic       in_name_ff, in_name_in;
   logic       open_ff, open_in;
   logic       nonempty_ff, nonempty_in;

   logic                           accept;
   logic [4:0]                     hv;
   logic                           plain;
   logic [fpd_pkg::CountW-1:0]     n;
   fpd_pkg::evt_type [fpd_pkg::MaxEvents-1:0] evs;

   assign req.ready = ~q_stat.full;
   assign accept    = req.valid & req.ready;

   // The decode steps, written out in order; n counts events so far.
   always_comb begin
      esc_in      = esc_ff;
      nib_in      = nib_ff;
      dig_in      = dig_ff;
      in_name_in  = in_name_ff;
      open_in     = open_ff;
      nonempty_in = nonempty_ff;
      n           = '0;
      evs         = '0;
      plain       = 1'b0;
      hv          = hex_value(req.ch);

      case (esc_ff)
         ESC_PCT: begin
            if (hv != NotHex) begin
               nib_in = hv[3:0];
               dig_in = req.ch;
               esc_in = ESC_DIG;
            end else begin
               esc_in = ESC_IDLE;
               evs[n[1:0]] = mk_evt(in_name_in ? fpd_pkg::KIND_NAME : fpd_pkg::KIND_VALUE,
                                    CharPct);
               n = n + 3'd1;
               nonempty_in = 1'b1;
               plain = 1'b1;
            end
         end
         ESC_DIG: begin
            esc_in = ESC_IDLE;
            if (hv != NotHex) begin
               evs[n[1:0]] = mk_evt(in_name_in ? fpd_pkg::KIND_NAME : fpd_pkg::KIND_VALUE,
                                    {nib_ff, hv[3:0]});
               n = n + 3'd1;
               nonempty_in = 1'b1;
            end else begin
               evs[n[1:0]] = mk_evt(in_name_in ? fpd_pkg::KIND_NAME : fpd_pkg::KIND_VALUE,
                                    CharPct);
               n = n + 3'd1;
               evs[n[1:0]] = mk_evt(in_name_in ? fpd_pkg::KIND_NAME : fpd_pkg::KIND_VALUE,
                                    dig_ff);
               n = n + 3'd1;
               nonempty_in = 1'b1;
               plain = 1'b1;
            end
         end
         default: begin
            esc_in = ESC_IDLE;
            plain  = 1'b1;
         end
      endcase

      if (plain) begin
         if (open_in) begin
            evs[n[1:0]] = mk_evt(fpd_pkg::KIND_OPEN, 8'h00);
            n = n + 3'd1;
            open_in     = 1'b0;
            nonempty_in = 1'b0;
         end
         if (req.ch == CharPct) begin
            esc_in = ESC_PCT;
         end else if (req.ch == CharAmp) begin
            if (nonempty_in) begin
               open_in     = 1'b1;
               in_name_in  = 1'b1;
               nonempty_in = 1'b0;
            end
         end else if (req.ch == CharEq && in_name_in) begin
            in_name_in = 1'b0;
         end else begin
            evs[n[1:0]] = mk_evt(in_name_in ? fpd_pkg::KIND_NAME : fpd_pkg::KIND_VALUE,
                                 req.ch);
            n = n + 3'd1;
            nonempty_in = 1'b1;
         end
      end

      if (req.last) begin
         if (esc_in == ESC_PCT) begin
            evs[n[1:0]] = mk_evt(in_name_in ? fpd_pkg::KIND_NAME : fpd_pkg::KIND_VALUE,
                                 CharPct);
            n = n + 3'd1;
         end else if (esc_in == ESC_DIG) begin
            evs[n[1:0]] = mk_evt(in_name_in ? fpd_pkg::KIND_NAME : fpd_pkg::KIND_VALUE,
                                 CharPct);
            n = n + 3'd1;
            evs[n[1:0]] = mk_evt(in_name_in ? fpd_pkg::KIND_NAME : fpd_pkg::KIND_VALUE,
                                 dig_in);
            n = n + 3'd1;
         end
         evs[n[1:0]] = mk_evt(fpd_pkg::KIND_END, 8'h00);
         n = n + 3'd1;
         esc_in      = ESC_IDLE;
         nib_in      = '0;
         dig_in      = '0;
         in_name_in  = 1'b1;
         open_in     = 1'b1;
         nonempty_in = 1'b0;
      end
   end

   assign push         = accept & (n != '0);
   assign bundle.evts  = evs;
   assign bundle.count = n;

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff      <= ESC_IDLE;
         nib_ff      <= '0;
         dig_ff      <= '0;
         in_name_ff  <= 1'b1;
         open_ff     <= 1'b1;
         nonempty_ff <= 1'b0;
      end else if (accept) begin
         esc_ff      <= esc_in;
         nib_ff      <= nib_in;
         dig_ff      <= dig_in;
         in_name_ff  <= in_name_in;
         open_ff     <= open_in;
         nonempty_ff <= nonempty_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/fpd_queue.sv
// Small FIFO of event bundles between the front end and the back end.
`default_nettype none

module fpd_queue #(
   parameter int unsigned Depth = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire fpd_pkg::bundle_type  wdata,
   input  wire logic                 pop,
   output fpd_pkg::bundle_type       rdata,
   output fpd_pkg::qstat_type        stat
);

   localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW  = $clog2(Depth + 1);

   fpd_pkg::bundle_type mem_ff [Depth];
   logic [AddrW-1:0]    wr_ff, rd_ff;
   logic [CntW-1:0]     cnt_ff;

   assign rdata      = mem_ff[rd_ff];
   assign stat.full  = (cnt_ff == CntW'(Depth));
   assign stat.empty = (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AddrW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == AddrW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

`ifndef ASSERT_OFF
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full) else $error("bundle pushed into a full queue");
   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty) else $error("bundle popped from an empty queue");
   a_push_nonzero: assert property (@(posedge clock) disable iff (reset)
      push |-> (wdata.count != '0 && wdata.count <= 3'd4))
      else $error("bundle pushed with a bad event count");
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      !stat.empty |-> (rdata.count != '0)) else $error("queue head holds no events");
`endif

endmodule

`default_nettype wire

// File: rtl/core/fpd_back.sv
// Back end: sends head bundle events one per unstalled cycle through an output register.
`default_nettype none

module fpd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fpd_pkg::bundle_type  head,
   input  wire fpd_pkg::qstat_type   q_stat,
   output logic                      pop,
   fpd_rsp_if.source                 rsp
);

   logic       valid_ff;
   logic [1:0] kind_ff;
   logic [7:0] data_ff;
   logic       run_end_ff;
   logic [1:0] idx_ff;

   logic             load;
   logic             final_evt;
   fpd_pkg::evt_type cur;

   assign cur       = head.evts[idx_ff];
   assign final_evt = (({1'b0, idx_ff} + 3'd1) == head.count);
   assign load      = ~q_stat.empty & (~valid_ff | rsp.ready);
   assign pop       = load & final_evt;

   assign rsp.valid   = valid_ff;
   assign rsp.kind    = kind_ff;
   assign rsp.data    = data_ff;
   assign rsp.run_end = run_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= final_evt ? '0 : idx_ff + 2'd1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= cur.kind;
         data_ff    <= cur.data;
         run_end_ff <= final_evt;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/form_params_decoder_top.sv
// Top level of the form parameter decoder.
// Each request transaction carries one byte of a form-encoded command string and a last flag;
// the block answers with zero to four response transactions: parameter open, name byte,
// value byte (with %XX escapes decoded) and end of message, run_end marking the final event
// of each request. The front end takes one request per cycle as long as the bundle queue
// (QueueDepth entries) has room. The back end sends one response per cycle, while the
// response side is ready, from a registered output stage, so the events of a request leave
// one at a time; a byte's first response passes through the bundle queue and then the output
// register. Sustained rate is one request per cycle whenever every request yields at most
// one event and the response side is ready.
`default_nettype none

module form_params_decoder_top #(
   parameter int unsigned QueueDepth = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   fpd_req_if.sink   req,
   fpd_rsp_if.source rsp
);

   logic                push;
   logic                pop;
   fpd_pkg::bundle_type wbundle;
   fpd_pkg::bundle_type head;
   fpd_pkg::qstat_type  q_stat;

   fpd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_stat (q_stat),
      .push   (push),
      .bundle (wbundle)
   );

   fpd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (wbundle),
      .pop   (pop),
      .rdata (head),
      .stat  (q_stat)
   );

   fpd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp    (rsp)
   );

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the form parameter decoder: byte streams in, decoded events checked.
module tb;

   localparam logic [7:0] PctChar = 8'h25;
   localparam logic [7:0] AmpChar = 8'h26;
   localparam logic [7:0] EqChar  = 8'h3D;
   localparam logic [4:0] NotHex  = 5'd16;

   localparam logic [1:0] EscIdle  = 2'd0;
   localparam logic [1:0] EscPct   = 2'd1;
   localparam logic [1:0] EscDigit = 2'd2;

   localparam int ByteTarget = 270;
   localparam int IdleLimit  = 2000;
   localparam int TailCycles = 20;

   typedef struct {
      logic [7:0] ch;
      logic       last;
      bit         drain_first;
   } form_byte_type;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] data;
      logic       run_end;
   } form_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fpd_req_if req_ch ();
   fpd_rsp_if rsp_ch ();

   form_params_decoder_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   form_byte_type  byte_queue[$];
   form_event_type events_due[$];
   form_event_type step_events[$];
   logic [7:0]     msg_bytes[$];
   string          hex_chars = "0123456789abcdefABCDEF";

   int   errors = 0;
   int   idle_cycles = 0;
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;
   int   req_hold = 0;
   int   rsp_hold = 0;
   bit   req_calm = 1'b0;
   bit   rsp_calm = 1'b0;

   // Decoder state as the predictor sees it.
   logic [1:0] esc_stage     = EscIdle;
   logic [3:0] held_val      = 4'd0;
   logic [7:0] held_char     = 8'd0;
   logic       filling_name  = 1'b1;
   logic       param_pending = 1'b1;
   logic       param_used    = 1'b0;

   function automatic int draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      if (b >= "0" && b <= "9") return {1'b0, b[3:0]};
      if (b >= "a" && b <= "f") return 5'(b - "a" + 10);
      if (b >= "A" && b <= "F") return 5'(b - "A" + 10);
      return NotHex;
   endfunction

   function automatic void note_event(input logic [1:0] kind, input logic [7:0] data);
      form_event_type e;
      if (step_events.size() < fpd_pkg::MaxEvents) begin
         e.kind = kind;
         e.data = data;
         e.run_end = 1'b0;
         step_events.push_back(e);
      end
   endfunction

   function automatic void append_char(input logic [7:0] b);
      note_event(filling_name ? fpd_pkg::KIND_NAME : fpd_pkg::KIND_VALUE, b);
      param_used = 1'b1;
   endfunction

   function automatic void plain_char(input logic [7:0] b);
      if (param_pending) begin
         note_event(fpd_pkg::KIND_OPEN, 8'd0);
         param_pending = 1'b0;
         param_used = 1'b0;
      end
      if (b == PctChar) begin
         esc_stage = EscPct;
      end else if (b == AmpChar) begin
         // An ampersand on an empty parameter is simply dropped.
         if (param_used) begin
            param_pending = 1'b1;
            filling_name = 1'b1;
            param_used = 1'b0;
         end
      end else if (b == EqChar && filling_name) begin
         filling_name = 1'b0;
      end else begin
         append_char(b);
      end
   endfunction

   function automatic void decode_form_byte(input logic [7:0] ch, input logic last);
      logic [4:0] nib;
      nib = hex_nibble(ch);
      step_events.delete();
      case (esc_stage)
         EscPct: begin
            if (nib != NotHex) begin
               held_val = nib[3:0];
               held_char = ch;
               esc_stage = EscDigit;
            end else begin
               esc_stage = EscIdle;
               append_char(PctChar);
               plain_char(ch);
            end
         end
         EscDigit: begin
            esc_stage = EscIdle;
            if (nib != NotHex) begin
               append_char({held_val, nib[3:0]});
            end else begin
               append_char(PctChar);
               append_char(held_char);
               plain_char(ch);
            end
         end
         default: begin
            esc_stage = EscIdle;
            plain_char(ch);
         end
      endcase
      if (last) begin
         // An escape cut short by the end of the message comes out literally.
         if (esc_stage == EscPct) begin
            append_char(PctChar);
         end else if (esc_stage == EscDigit) begin
            append_char(PctChar);
            append_char(held_char);
         end
         note_event(fpd_pkg::KIND_END, 8'd0);
         esc_stage = EscIdle;
         held_val = 4'd0;
         held_char = 8'd0;
         filling_name = 1'b1;
         param_pending = 1'b1;
         param_used = 1'b0;
      end
      if (step_events.size() != 0) begin
         step_events[step_events.size() - 1].run_end = 1'b1;
      end
      foreach (step_events[i]) begin
         events_due.push_back(step_events[i]);
      end
   endfunction

   function automatic void queue_byte(input logic [7:0] ch, input logic last, input bit drain);
      form_byte_type fb;
      fb.ch = ch;
      fb.last = last;
      fb.drain_first = drain;
      byte_queue.push_back(fb);
   endfunction

   function automatic void queue_text(input string s, input bit drain);
      for (int i = 0; i < s.len(); i++) begin
         queue_byte(s[i], i == s.len() - 1, drain && i == 0);
      end
   endfunction

   function automatic logic [7:0] plain_token_char();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(1, 255));
      end while (b == PctChar || b == AmpChar || b == EqChar);
      return b;
   endfunction

   // Appends one name or value piece: a plain byte, a good escape, or now and then a bad one.
   function automatic void add_token();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: msg_bytes.push_back(plain_token_char());
         5, 6, 7, 8: begin
            msg_bytes.push_back(PctChar);
            msg_bytes.push_back(hex_chars[$urandom_range(0, 21)]);
            msg_bytes.push_back(hex_chars[$urandom_range(0, 21)]);
         end
         default: begin
            msg_bytes.push_back(PctChar);
            if ($urandom_range(0, 1)) msg_bytes.push_back(hex_chars[$urandom_range(0, 21)]);
            msg_bytes.push_back(plain_token_char());
         end
      endcase
   endfunction

   function automatic logic [7:0] noise_char();
      case ($urandom_range(0, 4))
         0: return PctChar;
         1: return AmpChar;
         2: return EqChar;
         3: return hex_chars[$urandom_range(0, 21)];
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic void queue_random_message(input bit drain);
      msg_bytes.delete();
      if ($urandom_range(0, 3) != 0) begin
         for (int p = 0; p < $urandom_range(1, 3); p++) begin
            if (p != 0) msg_bytes.push_back(AmpChar);
            repeat ($urandom_range(1, 3)) add_token();
            msg_bytes.push_back(EqChar);
            repeat ($urandom_range(0, 3)) add_token();
         end
         if ($urandom_range(0, 3) == 0) msg_bytes.push_back(AmpChar);
      end else begin
         repeat ($urandom_range(1, 8)) msg_bytes.push_back(noise_char());
      end
      foreach (msg_bytes[i]) begin
         queue_byte(msg_bytes[i], i == msg_bytes.size() - 1, drain && i == 0);
      end
   endfunction

   // Request driver: one transaction at a time, random gap before each.
   always @(negedge clock) begin : req_driver
      form_byte_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_took) begin
         // Keep the current transaction on the bus until it is taken.
      end else if (req_hold > 0) begin
         req_ch.valid <= 1'b0;
         req_hold--;
      end else if (byte_queue.size() != 0 &&
                   !(byte_queue[0].drain_first && events_due.size() != 0)) begin
         nxt = byte_queue.pop_front();
         req_ch.ch <= nxt.ch;
         req_ch.last <= nxt.last;
         req_ch.valid <= 1'b1;
         if ($urandom_range(0, 15) == 0) req_calm = !req_calm;
         req_hold = draw_wait(req_calm);
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Response side: random stall after each accepted event.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_took) begin
            if ($urandom_range(0, 15) == 0) rsp_calm = !rsp_calm;
            rsp_hold = draw_wait(rsp_calm);
         end
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      form_event_type want;
      if (reset) begin
         req_took <= 1'b0;
         rsp_took <= 1'b0;
      end else begin
         req_took <= req_ch.valid && req_ch.ready;
         rsp_took <= rsp_ch.valid && rsp_ch.ready;
         if (req_ch.valid && req_ch.ready) decode_form_byte(req_ch.ch, req_ch.last);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (events_due.size() == 0) begin
               $error("unexpected event: kind %0d data 0x%02h run_end %0b",
                      rsp_ch.kind, rsp_ch.data, rsp_ch.run_end);
               errors++;
            end else begin
               want = events_due.pop_front();
               if (rsp_ch.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_ch.kind);
                  errors++;
               end
               if (rsp_ch.data !== want.data) begin
                  $error("data: expected 0x%02h, got 0x%02h", want.data, rsp_ch.data);
                  errors++;
               end
               if (rsp_ch.run_end !== want.run_end) begin
                  $error("run_end: expected %0b, got %0b", want.run_end, rsp_ch.run_end);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      bit mid_drain_done;
      req_ch.valid = 1'b0;
      req_ch.ch = 8'h01;
      req_ch.last = 1'b0;
      rsp_ch.ready = 1'b0;
      mid_drain_done = 1'b0;

      // Empty ampersand, separators, good escapes of both cases, escape cut by the end.
      queue_text("&=%41%fF&%", 1'b0);
      // Byte values 0x01 and 0xFF around a broken escape.
      queue_byte(8'h01, 1'b0, 1'b0);
      queue_byte(PctChar, 1'b0, 1'b0);
      queue_byte("4", 1'b0, 1'b0);
      queue_byte("z", 1'b0, 1'b0);
      queue_byte(8'hFF, 1'b1, 1'b0);
      // Escape with one digit cut by the end.
      queue_text("%A", 1'b0);
      // Decoded separators are data; a second equals sign is a value byte.
      queue_text("%3D%26==", 1'b0);

      queue_random_message(1'b1);
      while (byte_queue.size() < ByteTarget) begin
         if (!mid_drain_done && byte_queue.size() > ByteTarget / 2) begin
            queue_random_message(1'b1);
            mid_drain_done = 1'b1;
         end else begin
            queue_random_message(1'b0);
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_queue.size() != 0 || req_ch.valid || events_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (TailCycles) @(posedge clock);

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/fpd_pkg.sv
rtl/core/fpd_stream_if.sv
rtl/core/fpd_front.sv
rtl/core/fpd_queue.sv
rtl/core/fpd_back.sv
rtl/core/form_params_decoder_top.sv
sim/tb.sv
